@@ src/prc_pkg.sv @@
// Shared types, widths and codes for the pixel radiometric calibration pipeline.
package prc_pkg;

	// sensor geometry
	localparam int SENSOR_WIDTH = 1024;
	localparam int COL_W        = 11;

	// field widths
	localparam int DN_W    = 16;
	localparam int KIND_W  = 3;
	localparam int FLAT_W  = 16;
	localparam int LEVEL_W = 25;
	localparam int GAIN_W  = 24;
	localparam int CAL_W   = 32;

	// internal pixel path: signed Q.8, magnitude below 2^29
	localparam int PIX_W  = 30;
	localparam int MAG_W  = 29;
	localparam int FLAT_FRAC = 14;

	// divider: numerator of (mag << 14) + flat/2, quotient bits retired per stage
	localparam int NUM_W      = 44;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = NUM_W / DIV_BITS;

	// front stages, divider stages, gain stages (three products and saturation)
	localparam int FRONT_STAGES = 3;
	localparam int GAIN_STAGES  = 4;
	localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + GAIN_STAGES;

	// pixel kind codes
	localparam logic [KIND_W-1:0] KIND_NORMAL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NULL   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HRS    = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 25;
	localparam logic [CFG_IDX_W-1:0] REG_LOSSY_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_LEVEL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLAT_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd5;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd65536;

	// input word
	typedef struct packed {
		logic [DN_W-1:0]   raw_dn;
		logic [KIND_W-1:0] input_kind;
		logic [FLAT_W-1:0] flat_gain;
		logic              flat_is_special;
		logic [COL_W-1:0]  sensor_column;
	} pix_in_t;

	// result word
	typedef struct packed {
		logic signed [CAL_W-1:0] cal_value;
		logic [KIND_W-1:0]       output_kind;
	} pix_out_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic                      lossy_mode;
		logic                      bias_enable;
		logic signed [LEVEL_W-1:0] bias_level;
		logic signed [LEVEL_W-1:0] dark_level;
		logic                      flat_enable;
		logic [GAIN_W-1:0]         output_gain;
	} cfg_t;

	// control that travels with each word
	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
		logic              neg;
	} side_t;

endpackage

@@ src/pixel_radiometric_calibration.sv @@
// Top level: configuration registers and the calibration pipeline.
// Calibrates one raw camera pixel per clock: column check, special-kind pass-through,
// lossy x16 scale, bias and dark removal, flat-field division and Q8.16 gain with
// saturation. busy never rises, so a pixel may be started in every cycle. Each result
// appears on result with result_valid high for exactly one cycle; the receiver cannot
// stall and must take it then. The pipeline has 3 entry stages, 11 divider stages that
// each retire 4 quotient bits, and 4 gain and saturation stages. Results come out in
// start order. Configuration writes are always ready and must be made only while no
// pixel is in flight.
module pixel_radiometric_calibration (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  prc_pkg::pix_in_t                  pixel,
	output logic                              result_valid,
	output prc_pkg::pix_out_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	prc_pkg::cfg_t                cfg_q;
	logic                         accept;
	logic [prc_pkg::NUM_W-1:0]    num_s3;
	logic [prc_pkg::FLAT_W-1:0]   den_s3;
	prc_pkg::side_t               side_s3;
	logic [prc_pkg::NUM_W-1:0]    quot;
	prc_pkg::side_t               side_div;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lossy_mode  <= 1'b0;
			cfg_q.bias_enable <= 1'b1;
			cfg_q.bias_level  <= '0;
			cfg_q.dark_level  <= '0;
			cfg_q.flat_enable <= 1'b0;
			cfg_q.output_gain <= prc_pkg::GAIN_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				prc_pkg::REG_LOSSY_MODE:  cfg_q.lossy_mode  <= cfg_data[0];
				prc_pkg::REG_BIAS_ENABLE: cfg_q.bias_enable <= cfg_data[0];
				prc_pkg::REG_BIAS_LEVEL:  cfg_q.bias_level  <= $signed(cfg_data);
				prc_pkg::REG_DARK_LEVEL:  cfg_q.dark_level  <= $signed(cfg_data);
				prc_pkg::REG_FLAT_ENABLE: cfg_q.flat_enable <= cfg_data[0];
				prc_pkg::REG_OUTPUT_GAIN: cfg_q.output_gain <= cfg_data[prc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	prc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.pixel   (pixel),
		.cfg     (cfg_q),
		.num_s3  (num_s3),
		.den_s3  (den_s3),
		.side_s3 (side_s3)
	);

	prc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.num      (num_s3),
		.den      (den_s3),
		.side_in  (side_s3),
		.quot     (quot),
		.side_out (side_div)
	);

	prc_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.quot      (quot),
		.side_in   (side_div),
		.gain      (cfg_q.output_gain),
		.result_s4 (result),
		.valid_s4  (result_valid)
	);

`ifndef ASSERT_OFF
	// every result word comes from a pixel started a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept, prc_pkg::LATENCY))
		else $error("result word without a matching start");

	// a special or null result carries a zero value
	a_zero_special: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.output_kind != prc_pkg::KIND_NORMAL) |->
		result.cal_value == '0)
		else $error("nonzero value on a special result");

	// the output kind is always at most KIND_HRS
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.output_kind <= prc_pkg::KIND_HRS)
		else $error("undefined output kind");
`endif

endmodule

@@ src/prc_front.sv @@
// Entry stages: classification, lossy scale, bias and dark removal, divider operands.
module prc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  prc_pkg::pix_in_t            pixel,
	input  prc_pkg::cfg_t               cfg,
	output logic [prc_pkg::NUM_W-1:0]   num_s3,
	output logic [prc_pkg::FLAT_W-1:0]  den_s3,
	output prc_pkg::side_t              side_s3
);

	// stage 1 logic
	logic signed [prc_pkg::PIX_W-1:0] v0;
	logic signed [prc_pkg::PIX_W-1:0] bias_ext;
	logic signed [prc_pkg::PIX_W-1:0] diff;
	logic signed [prc_pkg::PIX_W-1:0] v1;
	logic                             col_bad;
	logic                             underflow;
	logic [prc_pkg::KIND_W-1:0]       kind1;

	logic signed [prc_pkg::PIX_W-1:0] v_s1;
	logic [prc_pkg::FLAT_W-1:0]       flat_s1;
	prc_pkg::side_t                   side_s1;

	// stage 2 logic
	logic signed [prc_pkg::PIX_W-1:0] dark_ext;
	logic signed [prc_pkg::PIX_W-1:0] w_s2;
	logic [prc_pkg::FLAT_W-1:0]       flat_s2;
	prc_pkg::side_t                   side_s2;

	// stage 3 logic
	logic                             neg;
	logic [prc_pkg::PIX_W-1:0]        mag_full;
	logic [prc_pkg::MAG_W-1:0]        mag;
	logic                             do_div;
	logic [prc_pkg::NUM_W-1:0]        num;
	logic [prc_pkg::FLAT_W-1:0]       den;

	// lossy scale, bias subtraction, kind decision
	always_comb begin
		v0 = cfg.lossy_mode
			? $signed({2'b00, pixel.raw_dn, 12'h000})
			: $signed({6'b000000, pixel.raw_dn, 8'h00});
		bias_ext = {{(prc_pkg::PIX_W-prc_pkg::LEVEL_W){cfg.bias_level[prc_pkg::LEVEL_W-1]}},
			cfg.bias_level};
		diff = v0 - bias_ext;
		underflow = diff[prc_pkg::PIX_W-1] || (diff == '0);
		v1 = cfg.bias_enable ? diff : v0;
		col_bad = (pixel.sensor_column == '0) ||
			({1'b0, pixel.sensor_column} >= (prc_pkg::COL_W+1)'(prc_pkg::SENSOR_WIDTH));
		if (col_bad) begin
			kind1 = prc_pkg::KIND_NULL;
		end else if (pixel.input_kind inside {[prc_pkg::KIND_NULL:prc_pkg::KIND_HRS]}) begin
			kind1 = pixel.input_kind;
		end else if (pixel.input_kind != prc_pkg::KIND_NORMAL) begin
			kind1 = prc_pkg::KIND_NULL;
		end else if (cfg.bias_enable && underflow) begin
			kind1 = prc_pkg::KIND_NULL;
		end else if (cfg.flat_enable && pixel.flat_is_special) begin
			kind1 = prc_pkg::KIND_NULL;
		end else begin
			kind1 = prc_pkg::KIND_NORMAL;
		end
	end

	// dark removal
	always_comb begin
		dark_ext = {{(prc_pkg::PIX_W-prc_pkg::LEVEL_W){cfg.dark_level[prc_pkg::LEVEL_W-1]}},
			cfg.dark_level};
	end

	// sign, magnitude and divider operands; divide by one when the flat is off or zero
	always_comb begin
		neg = w_s2[prc_pkg::PIX_W-1];
		mag_full = neg ? prc_pkg::PIX_W'(-w_s2) : prc_pkg::PIX_W'(w_s2);
		mag = mag_full[prc_pkg::MAG_W-1:0];
		do_div = cfg.flat_enable && (flat_s2 != '0);
		if (do_div) begin
			num = prc_pkg::NUM_W'({mag, {prc_pkg::FLAT_FRAC{1'b0}}}) +
				prc_pkg::NUM_W'(flat_s2[prc_pkg::FLAT_W-1:1]);
			den = flat_s2;
		end else begin
			num = prc_pkg::NUM_W'(mag);
			den = prc_pkg::FLAT_W'(1);
		end
	end

	// control stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
		end else begin
			side_s1.valid <= accept;
			side_s1.kind  <= kind1;
			side_s1.neg   <= 1'b0;
			side_s2       <= side_s1;
			side_s3.valid <= side_s2.valid;
			side_s3.kind  <= side_s2.kind;
			side_s3.neg   <= neg;
		end
	end

	// data stages
	always_ff @(posedge clk) begin
		v_s1    <= v1;
		flat_s1 <= pixel.flat_gain;
		w_s2    <= v_s1 - dark_ext;
		flat_s2 <= flat_s1;
		num_s3  <= num;
		den_s3  <= den;
	end

endmodule

@@ src/prc_div.sv @@
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module prc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [prc_pkg::NUM_W-1:0]   num,
	input  logic [prc_pkg::FLAT_W-1:0]  den,
	input  prc_pkg::side_t              side_in,
	output logic [prc_pkg::NUM_W-1:0]   quot,
	output prc_pkg::side_t              side_out
);

	// per-stage registers: partial remainder, numerator bits left and quotient bits
	logic [prc_pkg::FLAT_W-1:0] rem_s  [prc_pkg::DIV_STAGES];
	logic [prc_pkg::NUM_W-1:0]  nq_s   [prc_pkg::DIV_STAGES];
	logic [prc_pkg::FLAT_W-1:0] den_s  [prc_pkg::DIV_STAGES];
	prc_pkg::side_t             side_s [prc_pkg::DIV_STAGES];

	for (genvar k = 0; k < prc_pkg::DIV_STAGES; k++) begin : g_stage
		logic [prc_pkg::FLAT_W-1:0] rem_in;
		logic [prc_pkg::NUM_W-1:0]  nq_in;
		logic [prc_pkg::FLAT_W-1:0] den_in;
		prc_pkg::side_t             side_st;
		logic [prc_pkg::FLAT_W-1:0] rem_nx;
		logic [prc_pkg::NUM_W-1:0]  nq_nx;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign nq_in   = num;
			assign den_in  = den;
			assign side_st = side_in;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign nq_in   = nq_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_st = side_s[k-1];
		end

		// shift in DIV_BITS numerator bits one at a time, subtracting the divisor when it fits
		always_comb begin : step
			logic [prc_pkg::FLAT_W:0] r2;
			rem_nx = rem_in;
			nq_nx  = nq_in;
			r2     = '0;
			for (int b = 0; b < prc_pkg::DIV_BITS; b++) begin
				r2    = {rem_nx, nq_nx[prc_pkg::NUM_W-1]};
				nq_nx = {nq_nx[prc_pkg::NUM_W-2:0], 1'b0};
				if (r2 >= {1'b0, den_in}) begin
					rem_nx   = prc_pkg::FLAT_W'(r2 - {1'b0, den_in});
					nq_nx[0] = 1'b1;
				end else begin
					rem_nx = r2[prc_pkg::FLAT_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else begin
				side_s[k] <= side_st;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			nq_s[k]  <= nq_nx;
			den_s[k] <= den_in;
		end
	end

	assign quot     = nq_s[prc_pkg::DIV_STAGES-1];
	assign side_out = side_s[prc_pkg::DIV_STAGES-1];

endmodule

@@ src/prc_gain.sv @@
// Gain stages: rounded Q8.16 product in 16-bit slices, then saturation to 32 bits.
module prc_gain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [prc_pkg::NUM_W-1:0]   quot,
	input  prc_pkg::side_t              side_in,
	input  logic [prc_pkg::GAIN_W-1:0]  gain,
	output prc_pkg::pix_out_t           result_s4,
	output logic                        valid_s4
);

	localparam int SL_W  = 16;
	localparam int ACC_W = SL_W + prc_pkg::GAIN_W + 1;
	localparam int TOP_W = prc_pkg::NUM_W - 2*SL_W;
	localparam int HI_W  = TOP_W + prc_pkg::GAIN_W + 1;
	localparam int RES_W = prc_pkg::CAL_W - 1;

	// stage 1: low slice with the rounding half
	logic [ACC_W-1:0]                  acc_s1;
	logic [prc_pkg::NUM_W-SL_W-1:0]    q_s1;
	prc_pkg::side_t                    side_s1;
	// stage 2: middle slice
	logic [ACC_W-1:0]                  acc_s2;
	logic [TOP_W-1:0]                  q_s2;
	prc_pkg::side_t                    side_s2;
	// stage 3: top slice
	logic [HI_W-1:0]                   acc_s3;
	logic [SL_W-1:0]                   lo_s3;
	prc_pkg::side_t                    side_s3;

	logic                              sat;
	logic [RES_W-1:0]                  res;
	logic signed [prc_pkg::CAL_W-1:0]  value;

	// zero the value of special kinds, else saturate and apply the sign
	always_comb begin
		sat = |acc_s3[HI_W-1:RES_W-SL_W];
		res = {acc_s3[RES_W-SL_W-1:0], lo_s3};
		if (side_s3.kind != prc_pkg::KIND_NORMAL) begin
			value = '0;
		end else if (sat) begin
			value = side_s3.neg ? $signed({1'b1, {RES_W{1'b0}}}) : $signed({1'b0, {RES_W{1'b1}}});
		end else if (side_s3.neg) begin
			value = -$signed({1'b0, res});
		end else begin
			value = $signed({1'b0, res});
		end
	end

	// control stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1  <= '0;
			side_s2  <= '0;
			side_s3  <= '0;
			valid_s4 <= 1'b0;
		end else begin
			side_s1  <= side_in;
			side_s2  <= side_s1;
			side_s3  <= side_s2;
			valid_s4 <= side_s3.valid;
		end
	end

	// product slices, each above the low slice adding the carry of the one below
	always_ff @(posedge clk) begin
		acc_s1 <= ACC_W'(quot[SL_W-1:0] * gain) + ACC_W'(1 << (SL_W-1));
		q_s1   <= quot[prc_pkg::NUM_W-1:SL_W];
		acc_s2 <= ACC_W'(q_s1[SL_W-1:0] * gain) + ACC_W'(acc_s1[ACC_W-1:SL_W]);
		q_s2   <= q_s1[prc_pkg::NUM_W-SL_W-1:SL_W];
		acc_s3 <= HI_W'(q_s2 * gain) + HI_W'(acc_s2[ACC_W-1:SL_W]);
		lo_s3  <= acc_s2[SL_W-1:0];
		result_s4.cal_value   <= value;
		result_s4.output_kind <= side_s3.kind;
	end

endmodule

@@ dv/tb_pixel_radiometric_calibration.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the pixel calibration pipeline: directed and random pixels.
module tb_pixel_radiometric_calibration;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int WATCHDOG_LIMIT  = 2000;

	// tracks configuration, predicts each calibrated word and checks results in order
	class calib_scoreboard;
		prc_pkg::cfg_t     regs;
		prc_pkg::pix_out_t calibrated_q[$];
		int                mismatches;
		int                checked;
		int                normals;

		function new();
			regs.lossy_mode  = 1'b0;
			regs.bias_enable = 1'b1;
			regs.bias_level  = '0;
			regs.dark_level  = '0;
			regs.flat_enable = 1'b0;
			regs.output_gain = prc_pkg::GAIN_ONE;
			mismatches = 0;
			checked    = 0;
			normals    = 0;
		endfunction

		function void write_reg(logic [prc_pkg::CFG_IDX_W-1:0] idx,
				logic [prc_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				prc_pkg::REG_LOSSY_MODE:  regs.lossy_mode  = data[0];
				prc_pkg::REG_BIAS_ENABLE: regs.bias_enable = data[0];
				prc_pkg::REG_BIAS_LEVEL:  regs.bias_level  = data[prc_pkg::LEVEL_W-1:0];
				prc_pkg::REG_DARK_LEVEL:  regs.dark_level  = data[prc_pkg::LEVEL_W-1:0];
				prc_pkg::REG_FLAT_ENABLE: regs.flat_enable = data[0];
				prc_pkg::REG_OUTPUT_GAIN: regs.output_gain = data[prc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// sign-extend a Q.8 level register
		function longint level_of(logic [prc_pkg::LEVEL_W-1:0] x);
			logic signed [prc_pkg::LEVEL_W-1:0] s;
			s = x;
			return longint'(s);
		endfunction

		function prc_pkg::pix_out_t calibrate(prc_pkg::pix_in_t p);
			prc_pkg::pix_out_t o;
			longint            v;
			longint            d;
			longint unsigned   mag;
			longint unsigned   lo;
			longint unsigned   hi;
			longint unsigned   res;
			longint unsigned   negres;
			bit                neg;
			o.cal_value   = '0;
			o.output_kind = prc_pkg::KIND_NULL;
			// column check comes first, then special kinds
			if (p.sensor_column == 0 || p.sensor_column >= prc_pkg::SENSOR_WIDTH)
				return o;
			if (p.input_kind != prc_pkg::KIND_NORMAL) begin
				if (p.input_kind <= prc_pkg::KIND_HRS)
					o.output_kind = p.input_kind;
				return o;
			end
			v = {40'd0, p.raw_dn, 8'd0};
			if (regs.lossy_mode)
				v = v * 16;
			if (regs.bias_enable) begin
				d = v - level_of(regs.bias_level);
				if (d <= 0)
					return o;
				v = d;
			end
			v = v - level_of(regs.dark_level);
			neg = v < 0;
			mag = neg ? longint'(-v) : longint'(v);
			// flat division, rounded to nearest on the magnitude
			if (regs.flat_enable) begin
				if (p.flat_is_special)
					return o;
				if (p.flat_gain != 0)
					mag = ((mag << prc_pkg::FLAT_FRAC) + (p.flat_gain >> 1)) / p.flat_gain;
			end
			// Q8.16 gain, rounded, then saturate to 32 bits
			lo  = (mag & 64'hFFFF) * regs.output_gain;
			hi  = (mag >> 16) * regs.output_gain;
			res = hi + ((lo + 64'h8000) >> 16);
			if (neg) begin
				negres = 64'd0 - res;
				o.cal_value = (res >= 64'h8000_0000) ? 32'h8000_0000 : negres[31:0];
			end else begin
				o.cal_value = (res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : res[31:0];
			end
			o.output_kind = prc_pkg::KIND_NORMAL;
			return o;
		endfunction

		function void note_pixel(prc_pkg::pix_in_t p);
			calibrated_q.push_back(calibrate(p));
		endfunction

		function int pending();
			return calibrated_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(prc_pkg::pix_out_t r);
			prc_pkg::pix_out_t e;
			if (calibrated_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word value %0d kind %0d",
					r.cal_value, r.output_kind));
				return;
			end
			e = calibrated_q.pop_front();
			checked++;
			if (e.output_kind == prc_pkg::KIND_NORMAL)
				normals++;
			if (r.output_kind !== e.output_kind)
				report_mismatch($sformatf("output_kind expected %0d got %0d",
					e.output_kind, r.output_kind));
			if (r.cal_value !== e.cal_value)
				report_mismatch($sformatf("cal_value expected %0d got %0d (kind %0d)",
					e.cal_value, r.cal_value, e.output_kind));
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	prc_pkg::pix_in_t               pixel;
	logic                           result_valid;
	prc_pkg::pix_out_t              result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [prc_pkg::CFG_DATA_W-1:0] cfg_data;

	calib_scoreboard sb;
	int pixels_in;
	int settings_used;
	int quiet_cycles;

	pixel_radiometric_calibration dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// monitor: accepted pixels, results and register writes; watchdog on quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_pixel(pixel);
				pixels_in++;
			end
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (result_valid)
				sb.check_result(result);
			if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// drive tasks: entered and left at a falling edge
	task automatic send_pixel(input prc_pkg::pix_in_t p);
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause_send(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// hold off until every outstanding word has come back
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [prc_pkg::CFG_IDX_W-1:0] idx,
			input logic [prc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input bit lossy, input bit bias_en,
			input logic [prc_pkg::LEVEL_W-1:0] bias, input logic [prc_pkg::LEVEL_W-1:0] dark,
			input bit flat_en, input logic [prc_pkg::GAIN_W-1:0] gain);
		write_reg(prc_pkg::REG_LOSSY_MODE, prc_pkg::CFG_DATA_W'(lossy));
		write_reg(prc_pkg::REG_BIAS_ENABLE, prc_pkg::CFG_DATA_W'(bias_en));
		write_reg(prc_pkg::REG_BIAS_LEVEL, bias);
		write_reg(prc_pkg::REG_DARK_LEVEL, dark);
		write_reg(prc_pkg::REG_FLAT_ENABLE, prc_pkg::CFG_DATA_W'(flat_en));
		write_reg(prc_pkg::REG_OUTPUT_GAIN, prc_pkg::CFG_DATA_W'(gain));
		settings_used++;
	endtask

	function automatic prc_pkg::pix_in_t make_pixel(logic [prc_pkg::DN_W-1:0] dn,
			logic [prc_pkg::KIND_W-1:0] kind, logic [prc_pkg::FLAT_W-1:0] flat,
			logic special, logic [prc_pkg::COL_W-1:0] col);
		prc_pkg::pix_in_t p;
		p.raw_dn          = dn;
		p.input_kind      = kind;
		p.flat_gain       = flat;
		p.flat_is_special = special;
		p.sensor_column   = col;
		return p;
	endfunction

	// level mix: full range, small positive, small negative, zero
	function automatic logic [prc_pkg::LEVEL_W-1:0] random_level();
		case ($urandom_range(0, 3))
			0: return prc_pkg::LEVEL_W'($urandom);
			1: return prc_pkg::LEVEL_W'($urandom_range(0, 1 << 20));
			2: return prc_pkg::LEVEL_W'(-int'($urandom_range(0, 1 << 20)));
			default: return '0;
		endcase
	endfunction

	function automatic logic [prc_pkg::GAIN_W-1:0] random_gain();
		if ($urandom_range(0, 1))
			return prc_pkg::GAIN_W'($urandom_range(32768, 131072));
		return prc_pkg::GAIN_W'($urandom);
	endfunction

	// mostly in-range normal pixels, the rest noise over every field
	function automatic prc_pkg::pix_in_t random_pixel();
		prc_pkg::pix_in_t p;
		p.raw_dn = prc_pkg::DN_W'($urandom);
		case ($urandom_range(0, 3))
			0: p.flat_gain = '0;
			1: p.flat_gain = prc_pkg::FLAT_W'($urandom_range(1, 16));
			2: p.flat_gain = prc_pkg::FLAT_W'($urandom_range(8192, 32768));
			default: p.flat_gain = prc_pkg::FLAT_W'($urandom);
		endcase
		p.flat_is_special = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 4) != 0) begin
			p.input_kind    = prc_pkg::KIND_NORMAL;
			p.sensor_column = prc_pkg::COL_W'($urandom_range(1, prc_pkg::SENSOR_WIDTH - 1));
		end else begin
			p.input_kind    = prc_pkg::KIND_W'($urandom);
			p.sensor_column = prc_pkg::COL_W'($urandom);
		end
		return p;
	endfunction

	initial begin
		bit idle_on;
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		pixel         = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		pixels_in     = 0;
		settings_used = 1;
		quiet_cycles  = 0;
		sb = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: bias underflow, field extremes, column limits, every kind
		send_pixel(make_pixel(16'd0, prc_pkg::KIND_NORMAL, 16'd0, 1'b0, 11'd1));
		send_pixel(make_pixel(16'hFFFF, prc_pkg::KIND_NORMAL, 16'hFFFF, 1'b1, 11'd1023));
		send_pixel(make_pixel(16'd1, prc_pkg::KIND_NORMAL, 16'd0, 1'b0, 11'd0));
		send_pixel(make_pixel(16'd100, prc_pkg::KIND_NORMAL, 16'd0, 1'b0, 11'd1024));
		send_pixel(make_pixel(16'd100, prc_pkg::KIND_NORMAL, 16'd0, 1'b0, 11'h7FF));
		for (int k = 1; k < 8; k++)
			send_pixel(make_pixel(16'd500, prc_pkg::KIND_W'(k), 16'd0, 1'b0, 11'd500));
		send_pixel(make_pixel(16'd500, prc_pkg::KIND_HRS, 16'd0, 1'b0, 11'd0));

		// flat field on, lossy, no bias, largest dark and gain
		drain();
		set_config(1'b1, 1'b0, 25'h100_0000, 25'h0FF_FFFF, 1'b1, 24'hFF_FFFF);
		send_pixel(make_pixel(16'd0, prc_pkg::KIND_NORMAL, 16'd0, 1'b0, 11'd10));
		send_pixel(make_pixel(16'hFFFF, prc_pkg::KIND_NORMAL, 16'd16384, 1'b1, 11'd10));
		send_pixel(make_pixel(16'hFFFF, prc_pkg::KIND_NORMAL, 16'd1, 1'b0, 11'd10));
		send_pixel(make_pixel(16'hFFFF, prc_pkg::KIND_NORMAL, 16'hFFFF, 1'b0, 11'd10));
		send_pixel(make_pixel(16'hFFFF, prc_pkg::KIND_NORMAL, 16'd0, 1'b0, 11'd10));
		send_pixel(make_pixel(16'd1000, prc_pkg::KIND_NORMAL, 16'd16384, 1'b0, 11'd10));

		// random phases, each under its own register setting
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			if (phase == 0)
				set_config(1'b0, 1'b1, 25'h100_0000, 25'h100_0000, 1'b1, 24'd0);
			else if (phase == 1)
				set_config(1'b1, 1'b1, 25'h0FF_FFFF, 25'h0FF_FFFF, 1'b0, 24'hFF_FFFF);
			else
				set_config($urandom_range(0, 1), $urandom_range(0, 1), random_level(),
					random_level(), $urandom_range(0, 1), random_gain());
			idle_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (idle_on && $urandom_range(0, 3) == 0)
					pause_send($urandom_range(1, 6));
				if (phase == 2 && i == ITEMS_PER_PHASE / 2)
					drain();
				send_pixel(random_pixel());
			end
		end

		drain();
		repeat (prc_pkg::LATENCY + 4) @(negedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d words never came back", sb.pending()));
		$display("Covered %0d pixels under %0d register settings.", pixels_in, settings_used);
		$display("Checked %0d words, %0d of them normal, %0d mismatches.",
			sb.checked, sb.normals, sb.mismatches);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ pixel_radiometric_calibration.f @@
src/prc_pkg.sv
src/prc_front.sv
src/prc_div.sv
src/prc_gain.sv
src/pixel_radiometric_calibration.sv
dv/tb_pixel_radiometric_calibration.sv
